FILE: src/ttim_pkg.sv
`timescale 1ns / 1ps
// Package for the tensor transpose index map: register indexes, field widths,
// reset values and parameter defaults. No dependencies.
package ttim_pkg;

    localparam int MAX_DIMS_DEF   = 4;
    localparam int INDEX_BITS_DEF = 31;

    localparam int SIZE_REGS     = 4;
    localparam int SIZE_BITS     = 16;
    localparam int SEL_BITS      = 2;
    localparam int COUNT_BITS    = 3;
    localparam int PERM_BITS     = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_DIM_COUNT = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_REVERSE   = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_PERM      = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE0     = CFG_IDX_BITS'(3);

    localparam logic [COUNT_BITS-1:0] DIM_COUNT_RST = COUNT_BITS'(4);
    localparam logic [PERM_BITS-1:0]  PERM_RST      = PERM_BITS'(228);
    localparam logic [SIZE_BITS-1:0]  SIZE_RST      = SIZE_BITS'(1);

endpackage

FILE: src/tensor_transpose_index_map.sv
`timescale 1ns / 1ps
// Transposed address generator: splits a row-major index into coordinates,
// permutes them and recombines over the permuted shape. Uses ttim_pkg.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+------------------------------------------
//  cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data
//  req     | req_valid | req_ready | input_index
//  rsp     | rsp_valid | rsp_ready | output_index, run_length, index_error
//
// One transfer per cycle on req and rsp, unless the setup pass or a full skid holds them.
// After an input register, each of the D = min(MAX_DIMS, 4) dimensions takes a multiply by a
// stored reciprocal, a back-multiply and a correction stage, then one multiply stage and two
// add stages. After reset and after each config write a bit-serial reciprocal/stride pass
// runs; req_ready and cfg_ready are low meanwhile.
// A skid register at the output keeps the pipe moving one item past a stalled rsp;
// when it fills, the whole pipe holds.
module tensor_transpose_index_map #(
    parameter int MAX_DIMS   = ttim_pkg::MAX_DIMS_DEF,
    parameter int INDEX_BITS = ttim_pkg::INDEX_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ttim_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ttim_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [INDEX_BITS-1:0]              input_index,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic [INDEX_BITS-1:0]              output_index,
    output logic [INDEX_BITS-1:0]              run_length,
    output logic                               index_error
);

    localparam int DIMS   = (MAX_DIMS < ttim_pkg::SIZE_REGS) ? MAX_DIMS : ttim_pkg::SIZE_REGS;
    localparam int IB     = INDEX_BITS;
    localparam int SB     = ttim_pkg::SIZE_BITS;
    localparam int NB     = ttim_pkg::COUNT_BITS;
    localparam int SELB   = ttim_pkg::SEL_BITS;
    localparam int XW     = (IB > SB) ? IB : SB;
    localparam int RW     = XW + 1;
    localparam int CNT_W  = $clog2(IB + 1);
    localparam int TOT_W  = IB + 1;
    localparam int NCHAIN = 1 + 3 * DIMS;
    localparam int PAIRS  = (DIMS + 1) / 2;
    localparam int LANES  = 2 * PAIRS;

    typedef struct packed {
        logic                    err;
        logic [IB-1:0]           x;
        logic [IB-1:0]           qe;
        logic [IB-1:0]           t;
        logic [DIMS-1:0][SB-1:0] coord;
    } stage_t;

    // configuration registers
    logic [NB-1:0]                      dim_count_reg;
    logic                               reverse_reg;
    logic [ttim_pkg::PERM_BITS-1:0]     perm_reg;
    logic [DIMS-1:0][SB-1:0]            size_reg;
    logic                               cfg_wr;

    // derived from configuration
    logic [NB-1:0]                      n_act;
    logic [DIMS-1:0]                    act_c;
    logic [DIMS-1:0][DIMS-1:0]          sel_c;

    // setup pass
    logic                               busy_reg;
    logic [CNT_W-1:0]                   pass_cnt_reg;
    logic [IB-1:0]                      stride_acc_reg;
    logic                               run_live_reg;
    logic [DIMS-1:0][SB-1:0]            rem_reg;
    logic [DIMS-1:0][SB-1:0]            rem_next;
    logic [DIMS-1:0]                    qbit;
    logic [DIMS-1:0][IB:0]              recip_reg;
    logic [DIMS-1:0][IB-1:0]            stride_reg;
    logic [IB-1:0]                      run_reg;
    logic [TOT_W-1:0]                   total_reg;
    logic [DIMS-1:0][DIMS-1:0]          sel_reg;
    logic [DIMS-1:0]                    act_reg;
    logic [DIMS-1:0]                    hit;
    logic [SB-1:0]                      ssel;
    logic [SB-1:0]                      scur;
    logic                               hit_act;
    logic                               hit_id;
    logic [IB+SB-1:0]                   stride_prod;
    logic [IB+SB-1:0]                   run_prod;
    logic [IB+SB:0]                     total_prod;

    // datapath
    logic                               en;
    logic                               req_acc;
    stage_t                             stg_reg  [NCHAIN];
    stage_t                             stg_next [NCHAIN];
    logic [NCHAIN-1:0]                  vld_reg;
    logic                               p_vld_reg;
    logic                               p_err_reg;
    logic [LANES-1:0][IB-1:0]           prod_reg;
    logic [LANES-1:0][IB-1:0]           prod_next;
    logic                               a_vld_reg;
    logic                               a_err_reg;
    logic [PAIRS-1:0][IB-1:0]           pair_reg;
    logic [PAIRS-1:0][IB-1:0]           pair_next;
    logic [IB-1:0]                      sum_c;
    logic [IB-1:0]                      inc_idx;
    logic [IB-1:0]                      inc_run;
    logic                               inc_err;
    logic                               inc_v;

    // output and skid
    logic                               out_load;
    logic                               rsp_v_reg;
    logic                               skid_v_reg;
    logic [IB-1:0]                      out_idx_reg;
    logic [IB-1:0]                      out_run_reg;
    logic                               out_err_reg;
    logic [IB-1:0]                      skid_idx_reg;
    logic [IB-1:0]                      skid_run_reg;
    logic                               skid_err_reg;

    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_ready = !busy_reg;

    //------------------------------------------------------------------
    // configuration registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg <= ttim_pkg::DIM_COUNT_RST;
            reverse_reg   <= 1'b0;
            perm_reg      <= ttim_pkg::PERM_RST;
            for (int d = 0; d < DIMS; d++)
            begin
                size_reg[d] <= ttim_pkg::SIZE_RST;
            end
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                ttim_pkg::REG_DIM_COUNT: dim_count_reg <= cfg_data[NB-1:0];
                ttim_pkg::REG_REVERSE:   reverse_reg   <= cfg_data[0];
                ttim_pkg::REG_PERM:      perm_reg      <= cfg_data[ttim_pkg::PERM_BITS-1:0];
                default:
                begin
                    for (int d = 0; d < DIMS; d++)
                    begin
                        if (cfg_index == ttim_pkg::CFG_IDX_BITS'(ttim_pkg::REG_SIZE0 + d))
                        begin
                            size_reg[d] <= cfg_data[SB-1:0];
                        end
                    end
                end
            endcase
        end
    end

    // active count and one-hot source select for each output dimension
    always_comb
    begin
        logic [NB-1:0]   src;
        logic [SELB-1:0] p;
        n_act = dim_count_reg;
        if (dim_count_reg == '0)
        begin
            n_act = NB'(1);
        end
        else if (dim_count_reg > NB'(DIMS))
        begin
            n_act = NB'(DIMS);
        end
        for (int i = 0; i < DIMS; i++)
        begin
            act_c[i] = NB'(i) < n_act;
            p = perm_reg[SELB*i +: SELB];
            if (reverse_reg)
            begin
                src = n_act - NB'(1) - NB'(i);
            end
            else if (NB'(p) < n_act)
            begin
                src = NB'(p);
            end
            else
            begin
                src = '0;
            end
            for (int d = 0; d < DIMS; d++)
            begin
                sel_c[i][d] = act_c[i] && (src == NB'(d));
            end
        end
    end

    //------------------------------------------------------------------
    // setup pass: reciprocals floor(2^IB / size), one quotient bit per
    // cycle for all dims, and the stride / run / total products, one
    // output dim per cycle from the innermost outward
    //------------------------------------------------------------------
    always_comb
    begin
        logic [SB:0] rsh;
        ssel    = '0;
        scur    = '0;
        hit_act = 1'b0;
        hit_id  = 1'b0;
        for (int i = 0; i < DIMS; i++)
        begin
            hit[i] = pass_cnt_reg == CNT_W'(DIMS - 1 - i);
            if (hit[i])
            begin
                scur    = size_reg[i];
                hit_act = act_c[i];
                hit_id  = sel_c[i][i];
                for (int d = 0; d < DIMS; d++)
                begin
                    ssel = ssel | (sel_c[i][d] ? size_reg[d] : '0);
                end
            end
        end
        stride_prod = stride_acc_reg * ssel;
        run_prod    = run_reg * scur;
        total_prod  = total_reg * scur;

        // numerator is 2^IB: a single one in the first step
        for (int d = 0; d < DIMS; d++)
        begin
            rsh = {rem_reg[d], (pass_cnt_reg == '0)};
            if (rsh >= {1'b0, size_reg[d]})
            begin
                rem_next[d] = SB'(rsh - {1'b0, size_reg[d]});
                qbit[d]     = 1'b1;
            end
            else
            begin
                rem_next[d] = rsh[SB-1:0];
                qbit[d]     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            pass_cnt_reg   <= '0;
            stride_acc_reg <= IB'(1);
            run_live_reg   <= 1'b1;
            run_reg        <= IB'(1);
            total_reg      <= TOT_W'(1);
            rem_reg        <= '0;
            recip_reg      <= '0;
        end
        else if (cfg_wr)
        begin
            busy_reg       <= 1'b1;
            pass_cnt_reg   <= '0;
            stride_acc_reg <= IB'(1);
            run_live_reg   <= 1'b1;
            run_reg        <= IB'(1);
            total_reg      <= TOT_W'(1);
            rem_reg        <= '0;
            recip_reg      <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            for (int d = 0; d < DIMS; d++)
            begin
                recip_reg[d] <= {recip_reg[d][IB-1:0], qbit[d]};
            end
            if (hit_act)
            begin
                stride_acc_reg <= stride_prod[IB-1:0];
                // saturate once the count reaches 2^IB; any index is below that
                if (|total_prod[IB+SB:IB])
                begin
                    total_reg <= TOT_W'(1) << IB;
                end
                else
                begin
                    total_reg <= total_prod[IB:0];
                end
                if (run_live_reg && hit_id && !reverse_reg)
                begin
                    if (|run_prod[IB+SB-1:IB])
                    begin
                        run_reg <= '1;
                    end
                    else
                    begin
                        run_reg <= run_prod[IB-1:0];
                    end
                end
                else
                begin
                    run_live_reg <= 1'b0;
                end
            end
            if (pass_cnt_reg == CNT_W'(IB))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                pass_cnt_reg <= pass_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            sel_reg <= sel_c;
            act_reg <= act_c;
            for (int i = 0; i < DIMS; i++)
            begin
                if (hit[i])
                begin
                    stride_reg[i] <= hit_act ? stride_acc_reg : '0;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // split pipeline: per dim, multiply by reciprocal, back-multiply,
    // correct quotient by at most one
    //------------------------------------------------------------------
    assign en        = !skid_v_reg;
    assign req_ready = en && !busy_reg;
    assign req_acc   = req_valid && req_ready;

    always_comb
    begin
        logic [2*IB:0]    m1p;
        logic [IB+SB-1:0] m2p;
        logic [RW-1:0]    r;
        logic [RW-1:0]    dd;
        int               dm;
        stg_next[0].err   = TOT_W'(input_index) >= total_reg;
        stg_next[0].x     = input_index;
        stg_next[0].qe    = '0;
        stg_next[0].t     = '0;
        stg_next[0].coord = '0;
        for (int u = 0; u < DIMS; u++)
        begin
            dm = DIMS - 1 - u;

            stg_next[1+3*u]    = stg_reg[3*u];
            m1p                = stg_reg[3*u].x * recip_reg[dm];
            stg_next[1+3*u].qe = m1p[2*IB-1:IB];

            stg_next[2+3*u]    = stg_reg[1+3*u];
            m2p                = stg_reg[1+3*u].qe * size_reg[dm];
            stg_next[2+3*u].t  = m2p[IB-1:0];

            // estimate is exact or one short, so the remainder is below 2*size
            stg_next[3+3*u] = stg_reg[2+3*u];
            r  = RW'(stg_reg[2+3*u].x) - RW'(stg_reg[2+3*u].t);
            dd = RW'(size_reg[dm]);
            if (act_reg[dm])
            begin
                if (r >= dd)
                begin
                    stg_next[3+3*u].x         = stg_reg[2+3*u].qe + IB'(1);
                    stg_next[3+3*u].coord[dm] = SB'(r - dd);
                end
                else
                begin
                    stg_next[3+3*u].x         = stg_reg[2+3*u].qe;
                    stg_next[3+3*u].coord[dm] = SB'(r);
                end
            end
            else
            begin
                stg_next[3+3*u].coord[dm] = '0;
            end
        end
    end

    // gather coordinates per output dim and scale by its stride
    always_comb
    begin
        logic [SB-1:0]    csel;
        logic [IB+SB-1:0] pp;
        prod_next = '0;
        for (int i = 0; i < DIMS; i++)
        begin
            csel = '0;
            for (int d = 0; d < DIMS; d++)
            begin
                csel = csel | (sel_reg[i][d] ? stg_reg[NCHAIN-1].coord[d] : '0);
            end
            pp           = csel * stride_reg[i];
            prod_next[i] = pp[IB-1:0];
        end
        for (int j = 0; j < PAIRS; j++)
        begin
            pair_next[j] = prod_reg[2*j] + prod_reg[2*j+1];
        end
        sum_c = '0;
        for (int j = 0; j < PAIRS; j++)
        begin
            sum_c = sum_c + pair_reg[j];
        end
    end

    assign inc_err = a_err_reg;
    assign inc_idx = a_err_reg ? '0 : sum_c;
    assign inc_run = a_err_reg ? IB'(1) : run_reg;
    assign inc_v   = a_vld_reg && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            p_vld_reg <= 1'b0;
            a_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg   <= {vld_reg[NCHAIN-2:0], req_acc};
            p_vld_reg <= vld_reg[NCHAIN-1];
            a_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg   <= stg_next;
            p_err_reg <= stg_reg[NCHAIN-1].err;
            prod_reg  <= prod_next;
            a_err_reg <= p_err_reg;
            pair_reg  <= pair_next;
        end
    end

    //------------------------------------------------------------------
    // output register with skid
    //------------------------------------------------------------------
    assign out_load = !rsp_v_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_load)
        begin
            if (skid_v_reg)
            begin
                rsp_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                rsp_v_reg <= inc_v;
            end
        end
        else if (inc_v)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (skid_v_reg)
            begin
                out_idx_reg <= skid_idx_reg;
                out_run_reg <= skid_run_reg;
                out_err_reg <= skid_err_reg;
            end
            else
            begin
                out_idx_reg <= inc_idx;
                out_run_reg <= inc_run;
                out_err_reg <= inc_err;
            end
        end
        else if (inc_v)
        begin
            skid_idx_reg <= inc_idx;
            skid_run_reg <= inc_run;
            skid_err_reg <= inc_err;
        end
    end

    assign rsp_valid    = rsp_v_reg;
    assign output_index = out_idx_reg;
    assign run_length   = out_run_reg;
    assign index_error  = out_err_reg;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> rsp_v_reg)
        else $error("skid holds an item while the output register is empty");

    a_err_payload: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && index_error |-> (output_index == '0) && (run_length == IB'(1)))
        else $error("index error result carries a nonzero index or run");

    a_cfg_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> busy_reg && !req_ready && !cfg_ready)
        else $error("config write did not start the setup pass");
`endif

endmodule
